### src/assert_macros.svh
// Assertion macros for the token bucket policer checker.
// Uses clk and rst_n from the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define TBP_ASSERT_IMP(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("%m: check failed");

// next-cycle implication, checked outside reset
`define TBP_ASSERT_NXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("%m: check failed");

`endif

### src/tbp_pkg.sv
// Shared widths, constants and the pipeline item type of the token bucket policer.
// No dependencies.
package tbp_pkg;

    localparam int unsigned NUM_BUCKETS_DEF = 256;

    localparam int unsigned ID_W      = 10;
    localparam int unsigned ID_CMP_W  = ID_W + 1;
    localparam int unsigned LEN_W     = 16;
    localparam int unsigned TIME_W    = 64;
    localparam int unsigned RATE_W    = 36;
    localparam int unsigned BURST_W   = 32;

    localparam int unsigned ID_LSB    = 0;
    localparam int unsigned LEN_LSB   = ID_LSB + ID_W;
    localparam int unsigned NOW_LSB   = LEN_LSB + LEN_W;
    localparam int unsigned RATE_LSB  = NOW_LSB + TIME_W;
    localparam int unsigned BURST_LSB = RATE_LSB + RATE_W;
    localparam int unsigned IN_BITS   = BURST_LSB + BURST_W;
    localparam int unsigned IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int unsigned OUT_DATA_W = 8;

    // elapsed time, capped at one second
    localparam int unsigned ELAPSED_W = 30;
    localparam logic [ELAPSED_W-1:0] NS_PER_SEC = 30'd1000000000;

    // elapsed * rate, split over the rate
    localparam int unsigned RATE_LO_W = 18;
    localparam int unsigned RATE_HI_W = RATE_W - RATE_LO_W;
    localparam int unsigned PART_W    = ELAPSED_W + RATE_LO_W;
    localparam int unsigned PROD_W    = ELAPSED_W + RATE_W;

    // 8e9 = 2^12 * 5^9: shift, then divide by 5^9 through a reciprocal
    localparam int unsigned DIV_SHIFT = 12;
    localparam int unsigned X_W       = PROD_W - DIV_SHIFT;
    localparam int unsigned XT_SHIFT  = 20;
    localparam int unsigned XT_W      = X_W - XT_SHIFT;
    localparam int unsigned DIVISOR_W = 21;
    localparam logic [DIVISOR_W-1:0] DIVISOR = 21'd1953125;
    localparam int unsigned RECIP_W    = 35;
    localparam int unsigned RECIP_LO_W = 18;
    localparam int unsigned RECIP_HI_W = RECIP_W - RECIP_LO_W;
    localparam logic [RECIP_W-1:0] RECIP = 35'd18446744073;
    localparam int unsigned RECIP_SHIFT = 35;
    localparam int unsigned EST_W      = XT_W + RECIP_W;
    localparam int unsigned QA_W       = XT_W + RECIP_LO_W;
    localparam int unsigned QB_W       = XT_W + RECIP_HI_W;
    localparam int unsigned QUOT_W     = 34;
    localparam int unsigned REM_W      = 22;
    localparam int unsigned REM_PROD_W = 2 * REM_W;

    localparam int unsigned SUM_W = QUOT_W + 1;

    typedef struct packed {
        logic               valid;
        logic               policed;
        logic               first_use;
        logic [ID_W-1:0]    id;
        logic [LEN_W-1:0]   len;
        logic [BURST_W-1:0] burst;
    } item_t;

endpackage

### src/tbp_elapsed.sv
// Input stage: last-time memory with one-deep forwarding, first-use and elapsed time.
// Depends on tbp_pkg.
module tbp_elapsed #(
    parameter int unsigned NUM_BUCKETS = tbp_pkg::NUM_BUCKETS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          in_valid,
    input  logic [tbp_pkg::ID_W-1:0]      in_id,
    input  logic [tbp_pkg::LEN_W-1:0]     in_len,
    input  logic [tbp_pkg::TIME_W-1:0]    in_now,
    input  logic [tbp_pkg::RATE_W-1:0]    in_rate,
    input  logic [tbp_pkg::BURST_W-1:0]   in_burst,
    output tbp_pkg::item_t                out_item,
    output logic [tbp_pkg::ELAPSED_W-1:0] out_elapsed,
    output logic [tbp_pkg::RATE_W-1:0]    out_rate
);

    localparam int unsigned IDX_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;

    logic [tbp_pkg::TIME_W-1:0] last_mem [NUM_BUCKETS];
    logic [NUM_BUCKETS-1:0]     seen_reg;

    logic                          s1_valid_reg;
    logic                          s1_policed_reg;
    logic [tbp_pkg::ID_W-1:0]      s1_id_reg;
    logic [tbp_pkg::LEN_W-1:0]     s1_len_reg;
    logic [tbp_pkg::TIME_W-1:0]    s1_now_reg;
    logic [tbp_pkg::RATE_W-1:0]    s1_rate_reg;
    logic [tbp_pkg::BURST_W-1:0]   s1_burst_reg;
    logic [tbp_pkg::TIME_W-1:0]    last_rd_reg;
    logic                          seen_rd_reg;
    logic                          fwd_reg;
    logic [tbp_pkg::TIME_W-1:0]    fwd_now_reg;

    logic                          in_policed;
    logic                          wr_en;
    logic                          fwd_next;
    logic [IDX_W-1:0]              in_idx;
    logic [IDX_W-1:0]              s1_idx;
    logic [tbp_pkg::TIME_W-1:0]    last_eff;
    logic [tbp_pkg::TIME_W-1:0]    diff;
    logic [tbp_pkg::ELAPSED_W-1:0] elapsed;

    assign in_policed = (in_rate != '0)
                        && ({1'b0, in_id} < tbp_pkg::ID_CMP_W'(NUM_BUCKETS));
    assign in_idx   = in_id[IDX_W-1:0];
    assign s1_idx   = s1_id_reg[IDX_W-1:0];
    assign wr_en    = adv && s1_valid_reg && s1_policed_reg;
    assign fwd_next = s1_valid_reg && s1_policed_reg && (s1_id_reg == in_id);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            seen_reg     <= '0;
        end
        else
        begin
            if (adv)
            begin
                s1_valid_reg <= in_valid;
            end
            if (wr_en)
            begin
                seen_reg[s1_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_policed_reg <= in_policed;
            s1_id_reg      <= in_id;
            s1_len_reg     <= in_len;
            s1_now_reg     <= in_now;
            s1_rate_reg    <= in_rate;
            s1_burst_reg   <= in_burst;
            seen_rd_reg    <= seen_reg[in_idx];
            fwd_reg        <= fwd_next;
            fwd_now_reg    <= s1_now_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            last_rd_reg <= last_mem[in_idx];
        end
        if (wr_en)
        begin
            last_mem[s1_idx] <= s1_now_reg;
        end
    end

    always_comb
    begin
        if (fwd_reg)
        begin
            last_eff = fwd_now_reg;
        end
        else if (seen_rd_reg)
        begin
            last_eff = last_rd_reg;
        end
        else
        begin
            last_eff = '0;
        end

        diff = s1_now_reg - last_eff;
        // treat time going backwards as no elapsed time; cap at one second
        if (s1_now_reg <= last_eff)
        begin
            elapsed = '0;
        end
        else if ((diff[tbp_pkg::TIME_W-1:tbp_pkg::ELAPSED_W] != '0)
                 || (diff[tbp_pkg::ELAPSED_W-1:0] > tbp_pkg::NS_PER_SEC))
        begin
            elapsed = tbp_pkg::NS_PER_SEC;
        end
        else
        begin
            elapsed = diff[tbp_pkg::ELAPSED_W-1:0];
        end
    end

    always_comb
    begin
        out_item.valid     = s1_valid_reg;
        out_item.policed   = s1_policed_reg;
        out_item.first_use = (last_eff == '0);
        out_item.id        = s1_id_reg;
        out_item.len       = s1_len_reg;
        out_item.burst     = s1_burst_reg;
    end

    assign out_elapsed = elapsed;
    assign out_rate    = s1_rate_reg;

endmodule

### src/tbp_refill.sv
// Refill pipeline: elapsed * rate / 8e9, exact, over six register stages.
// Depends on tbp_pkg.
module tbp_refill (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  tbp_pkg::item_t                in_item,
    input  logic [tbp_pkg::ELAPSED_W-1:0] in_elapsed,
    input  logic [tbp_pkg::RATE_W-1:0]    in_rate,
    output tbp_pkg::item_t                out_item,
    output logic [tbp_pkg::QUOT_W-1:0]    out_refill
);

    tbp_pkg::item_t s2_item_reg;
    tbp_pkg::item_t s3_item_reg;
    tbp_pkg::item_t s4_item_reg;
    tbp_pkg::item_t s5_item_reg;
    tbp_pkg::item_t s6_item_reg;
    tbp_pkg::item_t s7_item_reg;

    logic [tbp_pkg::ELAPSED_W-1:0] s2_elapsed_reg;
    logic [tbp_pkg::RATE_W-1:0]    s2_rate_reg;
    logic [tbp_pkg::PART_W-1:0]    s3_pa_reg;
    logic [tbp_pkg::PART_W-1:0]    s3_pb_reg;
    logic [tbp_pkg::X_W-1:0]       s4_x_reg;
    logic [tbp_pkg::QA_W-1:0]      s5_qa_reg;
    logic [tbp_pkg::QB_W-1:0]      s5_qb_reg;
    logic [tbp_pkg::REM_W-1:0]     s5_xl_reg;
    logic [tbp_pkg::QUOT_W-1:0]    s6_qe_reg;
    logic [tbp_pkg::REM_W-1:0]     s6_xl_reg;
    logic [tbp_pkg::QUOT_W-1:0]    s7_qe_reg;
    logic [tbp_pkg::REM_W-1:0]     s7_xl_reg;
    logic [tbp_pkg::REM_W-1:0]     s7_qdl_reg;

    logic [tbp_pkg::PART_W-1:0]     pa;
    logic [tbp_pkg::PART_W-1:0]     pb;
    logic [tbp_pkg::PROD_W-1:0]     prod;
    logic [tbp_pkg::XT_W-1:0]       xt;
    logic [tbp_pkg::QA_W-1:0]       qa;
    logic [tbp_pkg::QB_W-1:0]       qb;
    logic [tbp_pkg::EST_W-1:0]      est;
    logic [tbp_pkg::REM_PROD_W-1:0] qd_full;
    logic [tbp_pkg::REM_W-1:0]      rem;
    logic                           rem_over;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_item_reg <= '0;
            s3_item_reg <= '0;
            s4_item_reg <= '0;
            s5_item_reg <= '0;
            s6_item_reg <= '0;
            s7_item_reg <= '0;
        end
        else if (adv)
        begin
            s2_item_reg <= in_item;
            s3_item_reg <= s2_item_reg;
            s4_item_reg <= s3_item_reg;
            s5_item_reg <= s4_item_reg;
            s6_item_reg <= s5_item_reg;
            s7_item_reg <= s6_item_reg;
        end
    end

    // partial products over the low and high halves of the rate
    assign pa = tbp_pkg::PART_W'(s2_elapsed_reg)
                * tbp_pkg::PART_W'(s2_rate_reg[tbp_pkg::RATE_LO_W-1:0]);
    assign pb = tbp_pkg::PART_W'(s2_elapsed_reg)
                * tbp_pkg::PART_W'(s2_rate_reg[tbp_pkg::RATE_W-1:tbp_pkg::RATE_LO_W]);

    assign prod = tbp_pkg::PROD_W'(s3_pa_reg)
                  + (tbp_pkg::PROD_W'(s3_pb_reg) << tbp_pkg::RATE_LO_W);

    // quotient estimate by 5^9 through the reciprocal, at most one short
    assign xt = s4_x_reg[tbp_pkg::X_W-1:tbp_pkg::XT_SHIFT];
    assign qa = tbp_pkg::QA_W'(xt) * tbp_pkg::QA_W'(tbp_pkg::RECIP[tbp_pkg::RECIP_LO_W-1:0]);
    assign qb = tbp_pkg::QB_W'(xt)
                * tbp_pkg::QB_W'(tbp_pkg::RECIP[tbp_pkg::RECIP_W-1:tbp_pkg::RECIP_LO_W]);

    assign est = tbp_pkg::EST_W'(s5_qa_reg)
                 + (tbp_pkg::EST_W'(s5_qb_reg) << tbp_pkg::RECIP_LO_W);

    assign qd_full = tbp_pkg::REM_PROD_W'(s6_qe_reg[tbp_pkg::REM_W-1:0])
                     * tbp_pkg::REM_PROD_W'(tbp_pkg::DIVISOR);

    // remainder stays below twice the divisor, so its low bits are exact
    assign rem      = s7_xl_reg - s7_qdl_reg;
    assign rem_over = (rem >= tbp_pkg::REM_W'(tbp_pkg::DIVISOR));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_elapsed_reg <= in_elapsed;
            s2_rate_reg    <= in_rate;
            s3_pa_reg      <= pa;
            s3_pb_reg      <= pb;
            s4_x_reg       <= prod[tbp_pkg::PROD_W-1:tbp_pkg::DIV_SHIFT];
            s5_qa_reg      <= qa;
            s5_qb_reg      <= qb;
            s5_xl_reg      <= s4_x_reg[tbp_pkg::REM_W-1:0];
            s6_qe_reg      <= est[tbp_pkg::EST_W-1:tbp_pkg::RECIP_SHIFT];
            s6_xl_reg      <= s5_xl_reg;
            s7_qe_reg      <= s6_qe_reg;
            s7_xl_reg      <= s6_xl_reg;
            s7_qdl_reg     <= qd_full[tbp_pkg::REM_W-1:0];
        end
    end

    assign out_item   = s7_item_reg;
    assign out_refill = s7_qe_reg + tbp_pkg::QUOT_W'(rem_over);

endmodule

### src/tbp_bucket.sv
// Bucket update stage: token memory with forwarding, clamp, debit and result register.
// Depends on tbp_pkg.
module tbp_bucket #(
    parameter int unsigned NUM_BUCKETS = tbp_pkg::NUM_BUCKETS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       adv,
    input  tbp_pkg::item_t             in_item,
    input  logic [tbp_pkg::QUOT_W-1:0] in_refill,
    output logic                       out_valid,
    output logic                       out_admit
);

    localparam int unsigned IDX_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;

    logic [tbp_pkg::BURST_W-1:0] tok_mem [NUM_BUCKETS];

    tbp_pkg::item_t              s8_item_reg;
    logic [tbp_pkg::QUOT_W-1:0]  s8_refill_reg;
    logic [tbp_pkg::BURST_W-1:0] tok_rd_reg;
    logic                        tok_fwd_reg;
    logic [tbp_pkg::BURST_W-1:0] tok_fwd_val_reg;
    logic                        out_valid_reg;
    logic                        out_admit_reg;

    logic                        wr_en;
    logic [IDX_W-1:0]            in_idx;
    logic [IDX_W-1:0]            s8_idx;
    logic [tbp_pkg::BURST_W-1:0] tok_old;
    logic [tbp_pkg::SUM_W-1:0]   tok_sum;
    logic [tbp_pkg::BURST_W-1:0] tok_base;
    logic [tbp_pkg::BURST_W-1:0] tok_new;
    logic                        enough;
    logic                        admit;

    assign in_idx = in_item.id[IDX_W-1:0];
    assign s8_idx = s8_item_reg.id[IDX_W-1:0];
    assign wr_en  = adv && s8_item_reg.valid && s8_item_reg.policed;

    always_comb
    begin
        tok_old = tok_fwd_reg ? tok_fwd_val_reg : tok_rd_reg;
        tok_sum = tbp_pkg::SUM_W'(tok_old) + tbp_pkg::SUM_W'(s8_refill_reg);
        if (s8_item_reg.first_use)
        begin
            tok_base = s8_item_reg.burst;
        end
        else if (tok_sum > tbp_pkg::SUM_W'(s8_item_reg.burst))
        begin
            tok_base = s8_item_reg.burst;
        end
        else
        begin
            tok_base = tok_sum[tbp_pkg::BURST_W-1:0];
        end
        enough  = (tok_base >= tbp_pkg::BURST_W'(s8_item_reg.len));
        tok_new = enough ? (tok_base - tbp_pkg::BURST_W'(s8_item_reg.len)) : tok_base;
        admit   = !s8_item_reg.policed || enough;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s8_item_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s8_item_reg   <= in_item;
            out_valid_reg <= s8_item_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s8_refill_reg   <= in_refill;
            tok_fwd_reg     <= s8_item_reg.valid && s8_item_reg.policed
                               && (s8_item_reg.id == in_item.id);
            tok_fwd_val_reg <= tok_new;
            out_admit_reg   <= admit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tok_rd_reg <= tok_mem[in_idx];
        end
        if (wr_en)
        begin
            tok_mem[s8_idx] <= tok_new;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_admit = out_admit_reg;

endmodule

### src/token_bucket_policer.sv
// Per-flow token bucket policer; depends on tbp_pkg, tbp_elapsed, tbp_refill, tbp_bucket.
// After the input transfer, a packet passes through stages s1 to s8, then the result register.
// Throughput: one packet per cycle while no result is blocked; the bucket update stage forwards its own write.
// A blocked result stalls the whole pipeline and holds s_axis_tready low.
// Reset (rst_n low, asynchronous) empties the pipeline and marks every bucket unused.
module token_bucket_policer #(
    parameter int unsigned NUM_BUCKETS = tbp_pkg::NUM_BUCKETS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // bucket_id[9:0], packet_bytes[25:10], now_ns[89:26],
    // rate_bits_per_sec[125:90], burst_limit_bytes[157:126], zero[159:158]
    input  logic [tbp_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // admit[0], zero[7:1]
    output logic [tbp_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    logic                          adv;
    logic                          admit;
    tbp_pkg::item_t                s1_item;
    tbp_pkg::item_t                s7_item;
    logic [tbp_pkg::ELAPSED_W-1:0] s1_elapsed;
    logic [tbp_pkg::RATE_W-1:0]    s1_rate;
    logic [tbp_pkg::QUOT_W-1:0]    s7_refill;

    // advance every stage unless a result is waiting
    assign adv           = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    tbp_elapsed #(
        .NUM_BUCKETS (NUM_BUCKETS)
    ) u_elapsed (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .in_valid    (s_axis_tvalid),
        .in_id       (s_axis_tdata[tbp_pkg::ID_LSB +: tbp_pkg::ID_W]),
        .in_len      (s_axis_tdata[tbp_pkg::LEN_LSB +: tbp_pkg::LEN_W]),
        .in_now      (s_axis_tdata[tbp_pkg::NOW_LSB +: tbp_pkg::TIME_W]),
        .in_rate     (s_axis_tdata[tbp_pkg::RATE_LSB +: tbp_pkg::RATE_W]),
        .in_burst    (s_axis_tdata[tbp_pkg::BURST_LSB +: tbp_pkg::BURST_W]),
        .out_item    (s1_item),
        .out_elapsed (s1_elapsed),
        .out_rate    (s1_rate)
    );

    tbp_refill u_refill (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_item    (s1_item),
        .in_elapsed (s1_elapsed),
        .in_rate    (s1_rate),
        .out_item   (s7_item),
        .out_refill (s7_refill)
    );

    tbp_bucket #(
        .NUM_BUCKETS (NUM_BUCKETS)
    ) u_bucket (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_item   (s7_item),
        .in_refill (s7_refill),
        .out_valid (m_axis_tvalid),
        .out_admit (admit)
    );

    assign m_axis_tdata = {{(tbp_pkg::OUT_DATA_W-1){1'b0}}, admit};

endmodule

### src/tbp_checker.sv
// Port-level checks on the token bucket policer, bound to the top level.
// Depends on tbp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tbp_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [tbp_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    logic in_xfer;

    assign in_xfer = s_axis_tvalid && s_axis_tready;

    `TBP_ASSERT_NXT(a_result_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `TBP_ASSERT_IMP(a_ready_when_empty, !m_axis_tvalid, s_axis_tready)
    `TBP_ASSERT_IMP(a_no_transfer_blocked, m_axis_tvalid && !m_axis_tready, !in_xfer)
    `TBP_ASSERT_IMP(a_result_pad_zero, m_axis_tvalid, m_axis_tdata[tbp_pkg::OUT_DATA_W-1:1] == '0)

endmodule

bind token_bucket_policer tbp_checker u_tbp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
